/* rtl/tsf_pkg.sv */
// Package: shared widths, codes and state encoding for the temperature sample filter.
package tsf_pkg;

    // Moving average depth and derived widths
    localparam int AVG_DEPTH = 10;
    localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W    = $clog2(AVG_DEPTH + 1);

    // Fixed field widths
    localparam int RAW_W    = 16;
    localparam int TEMP_W   = 20;
    localparam int SUM_W    = 24;
    localparam int TICK_W   = 32;
    localparam int OFFSET_W = 14;
    localparam int DELTA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    // C to F conversion: f = 9*raw + 2560 (1/16 C in, 1/80 F out)
    localparam logic signed [TEMP_W-1:0] F_BIAS = TEMP_W'(2560);

    // Register reset values
    localparam logic [DELTA_W-1:0] MAX_DELTA_RST = DELTA_W'(3200);
    localparam logic [TICK_W-1:0]  TIMEOUT_RST   = TICK_W'(2000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Input action and output kind codes
    localparam logic ACT_GOOD     = 1'b0;
    localparam logic ACT_FAIL     = 1'b1;
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_FIX,
        S_EMIT
    } tsf_state_t;

endpackage

/* rtl/tsf_if.sv */
// Interfaces: reading input, result output and configuration write channels.
interface tsf_in_if
    import tsf_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [RAW_W-1:0]  raw_temp;
    logic [TICK_W-1:0]        now_ticks;

    modport source (output valid, action, raw_temp, now_ticks, input ready);
    modport sink   (input valid, action, raw_temp, now_ticks, output ready);
endinterface

interface tsf_out_if
    import tsf_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [TEMP_W-1:0] value;
    logic                     connected;

    modport source (output valid, kind, value, connected, input ready);
    modport sink   (input valid, kind, value, connected, output ready);
endinterface

interface tsf_cfg_if
    import tsf_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/temp_sample_filter_with_timeout.sv */
// Top level: temperature sample filter with moving average, outlier rejection and link timeout.
//
// Each transfer on sample_in is a good probe reading (action 0) or a failed read (action 1).
// A good reading is converted to 1/80 degree F, passed through a 10-entry ring moving
// average (sum divided by entries filled so far, truncated toward zero), offset by
// probe_offset and returned as a sample with connected set. Once the ring is full, a
// reading further than max_delta from the last average is dropped and the last average
// is returned again. A failed read returns one timeout event (value 0, connected 0) when
// the link is up and more than timeout_ticks have passed since the last good reading;
// otherwise it returns nothing. One item is in work at a time. A good reading passes
// through the fetch, update, prep, divide, fix and emit states, the divide state being
// the bit-serial divider (24 iterations, one quotient bit per cycle); a rejected reading
// goes from update straight to emit, a failed read with a timeout event goes straight to
// emit, and one without stays idle. Output backpressure stalls the emit state only when
// a previous result is still unclaimed. The ring lives in a small synchronous RAM; entries
// not yet written are never used because the fill count shows the slot as empty.
// Configuration writes are always taken and must only be issued while the block is idle.
module temp_sample_filter_with_timeout
    import tsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tsf_in_if.sink     sample_in,
    tsf_out_if.source  result_out,
    tsf_cfg_if.sink    cfg
);

    // Configuration registers
    logic signed [OFFSET_W-1:0] probe_offset_reg;
    logic [DELTA_W-1:0]         max_delta_reg;
    logic [TICK_W-1:0]          timeout_ticks_reg;

    // Filter and link state
    logic [IDX_W-1:0]   ring_index_reg;
    logic [FILL_W-1:0]  fill_count_reg;
    sum_t               running_sum_reg;
    temp_t              last_average_reg;
    logic [TICK_W-1:0]  last_good_time_reg;
    logic               link_up_reg;

    // Captured item
    logic               act_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic [TICK_W-1:0]  now_reg;
    temp_t              f_reg;

    // Divider
    logic [SUM_W-1:0]     div_q_reg;
    logic [FILL_W-1:0]    div_rem_reg;
    logic                 div_neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Output register
    logic               out_valid_reg;
    logic               out_kind_reg;
    temp_t              out_value_reg;
    logic               out_connected_reg;

    // Ring RAM, registered read
    temp_t              ring_mem [AVG_DEPTH];
    temp_t              ring_rdata_reg;

    tsf_state_t state_reg, state_next;

    // Handshake and control
    logic in_fire;
    logic emit_load;
    logic ring_we;
    logic timeout_hit;
    logic ring_full;
    logic reject;

    logic [TICK_W-1:0]   elapsed;
    temp_t               raw_ext;
    temp_t               f_calc;
    temp_t               old_sample;
    logic signed [TEMP_W:0] diff;
    logic [TEMP_W:0]     mag;
    sum_t                sum_next;
    logic [SUM_W-1:0]    sum_mag;
    logic [FILL_W:0]     rem_shift;
    logic                rem_ge;
    logic [FILL_W:0]     rem_sub;
    logic [SUM_W-1:0]    quot_signed;
    temp_t               emit_value;

    //------------------------------------------------------------------
    // Configuration port: always ready
    //------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_offset_reg  <= '0;
            max_delta_reg     <= MAX_DELTA_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PROBE_OFFSET:  probe_offset_reg  <= cfg.data[OFFSET_W-1:0];
                CFG_MAX_DELTA:     max_delta_reg     <= cfg.data[DELTA_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Datapath terms
    //------------------------------------------------------------------
    assign in_fire = sample_in.valid && sample_in.ready;

    // Wrapping elapsed time, strict compare
    assign elapsed     = sample_in.now_ticks - last_good_time_reg;
    assign timeout_hit = link_up_reg && (elapsed > timeout_ticks_reg);

    // f = 9*raw + 2560 as shift and add
    assign raw_ext = TEMP_W'(raw_reg);
    assign f_calc  = (raw_ext <<< 3) + raw_ext + F_BIAS;

    // Slot at ring_index is unwritten until the ring has filled
    assign ring_full  = (fill_count_reg == FILL_W'(AVG_DEPTH));
    assign old_sample = ring_full ? ring_rdata_reg : '0;

    assign diff   = (TEMP_W+1)'(f_reg) - (TEMP_W+1)'(last_average_reg);
    assign mag    = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : (TEMP_W+1)'(diff);
    assign reject = ring_full && (mag > (TEMP_W+1)'(max_delta_reg));

    assign sum_next = running_sum_reg - SUM_W'(old_sample) + SUM_W'(f_reg);

    assign sum_mag = running_sum_reg[SUM_W-1] ? SUM_W'(-running_sum_reg)
                                              : SUM_W'(running_sum_reg);

    // Restoring divide step: one quotient bit per cycle
    assign rem_shift = {div_rem_reg, div_q_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, fill_count_reg});
    assign rem_sub   = rem_shift - {1'b0, fill_count_reg};

    assign quot_signed = div_neg_reg ? (~div_q_reg + SUM_W'(1)) : div_q_reg;

    assign emit_value = last_average_reg + TEMP_W'(probe_offset_reg);

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (sample_in.action == ACT_GOOD)
                        state_next = S_FETCH;
                    else if (timeout_hit)
                        state_next = S_EMIT;
                end
            end
            S_FETCH:  state_next = S_UPDATE;
            S_UPDATE: state_next = reject ? S_EMIT : S_PREP;
            S_PREP:   state_next = S_DIV;
            S_DIV:    state_next = (div_cnt_reg == '0) ? S_FIX : S_DIV;
            S_FIX:    state_next = S_EMIT;
            S_EMIT:   state_next = emit_load ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        sample_in.ready = (state_reg == S_IDLE);
        ring_we         = (state_reg == S_UPDATE) && !reject;
        emit_load       = (state_reg == S_EMIT) && (!out_valid_reg || result_out.ready);
    end

    //------------------------------------------------------------------
    // Ring RAM
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_index_reg] <= f_reg;
        ring_rdata_reg <= ring_mem[ring_index_reg];
    end

    //------------------------------------------------------------------
    // Item capture and divider payload
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= sample_in.action;
            raw_reg <= sample_in.raw_temp;
            now_reg <= sample_in.now_ticks;
        end
        if (state_reg == S_FETCH)
            f_reg <= f_calc;
        if (state_reg == S_PREP)
        begin
            div_q_reg   <= sum_mag;
            div_neg_reg <= running_sum_reg[SUM_W-1];
            div_rem_reg <= '0;
            div_cnt_reg <= DIV_CNT_W'(SUM_W - 1);
        end
        else if (state_reg == S_DIV)
        begin
            div_q_reg   <= {div_q_reg[SUM_W-2:0], rem_ge};
            div_rem_reg <= rem_ge ? rem_sub[FILL_W-1:0] : rem_shift[FILL_W-1:0];
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    //------------------------------------------------------------------
    // Filter and link state
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_index_reg     <= '0;
            fill_count_reg     <= '0;
            running_sum_reg    <= '0;
            last_average_reg   <= '0;
            last_good_time_reg <= '0;
            link_up_reg        <= 1'b0;
        end
        else
        begin
            if (ring_we)
            begin
                running_sum_reg <= sum_next;
                ring_index_reg  <= (ring_index_reg == IDX_W'(AVG_DEPTH - 1))
                                   ? '0 : ring_index_reg + IDX_W'(1);
                if (!ring_full)
                    fill_count_reg <= fill_count_reg + FILL_W'(1);
            end
            if (state_reg == S_FIX)
                last_average_reg <= quot_signed[TEMP_W-1:0];
            if (emit_load)
            begin
                if (act_reg == ACT_GOOD)
                begin
                    link_up_reg        <= 1'b1;
                    last_good_time_reg <= now_reg;
                end
                else
                    link_up_reg <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Output register: holds a result until transferred
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            if (act_reg == ACT_GOOD)
            begin
                out_kind_reg      <= KIND_SAMPLE;
                out_value_reg     <= emit_value;
                out_connected_reg <= 1'b1;
            end
            else
            begin
                out_kind_reg      <= KIND_TIMEOUT;
                out_value_reg     <= '0;
                out_connected_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.kind      = out_kind_reg;
    assign result_out.value     = out_value_reg;
    assign result_out.connected = out_connected_reg;

`ifndef SYNTHESIS
    // Fill count saturates at the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(AVG_DEPTH))
        else $error("fill count beyond ring depth");

    // Write pointer stays inside the ring
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_index_reg < IDX_W'(AVG_DEPTH))
        else $error("ring index out of range");

    // An empty ring has a zero sum
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg == '0) |-> (running_sum_reg == '0))
        else $error("nonzero sum with empty ring");

    // A ring write always advances the fill count or the ring is already full
    a_write_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |=> (fill_count_reg != '0))
        else $error("ring write left fill count at zero");
`endif

endmodule
